// File: rtl/b2bcd_pkg.sv
`default_nettype none

package b2bcd_pkg;

	// field widths
	localparam int ValueW = 14;
	localparam int BcdW   = 16;
	localparam int ScrW   = BcdW + ValueW;
	localparam int DwellW = 8;
	localparam int PosW   = 2;
	localparam int DigitW = 4;
	localparam int CfgIdxW = 2;

	// shift-add-3 steps ahead of each pipeline register; the first three
	// steps only shift, so the input stage takes more of them
	localparam int StepsS1 = 6;
	localparam int StepsS2 = 4;
	localparam int StepsS3 = ValueW - StepsS1 - StepsS2;

	localparam logic [ValueW-1:0] MaxShown = ValueW'(9999);

	// register indexes on the config port
	localparam logic [CfgIdxW-1:0] RegDwellHundreds = CfgIdxW'(0);
	localparam logic [CfgIdxW-1:0] RegDwellOther    = CfgIdxW'(1);

	localparam logic [DwellW-1:0] DwellHundredsRst = DwellW'(5);
	localparam logic [DwellW-1:0] DwellOtherRst    = DwellW'(2);

	// digit positions
	localparam logic [PosW-1:0] PosUnits     = PosW'(0);
	localparam logic [PosW-1:0] PosTens      = PosW'(1);
	localparam logic [PosW-1:0] PosHundreds  = PosW'(2);
	localparam logic [PosW-1:0] PosThousands = PosW'(3);

	// one double-dabble step: correct each BCD digit, then shift left
	function automatic logic [ScrW-1:0] dabble_step(input logic [ScrW-1:0] x);
		logic [ScrW-1:0] t;
		t = x;
		for (int d = 0; d < BcdW / DigitW; d++) begin
			if (t[ValueW + DigitW*d +: DigitW] >= DigitW'(5)) begin
				t[ValueW + DigitW*d +: DigitW] = t[ValueW + DigitW*d +: DigitW] + DigitW'(3);
			end
		end
		return {t[ScrW-2:0], 1'b0};
	endfunction

endpackage

`default_nettype wire

// File: rtl/binary_to_bcd_digit_scan.sv
`default_nettype none
// Binary to BCD digit scan for a four-digit multiplexed display.
// Slave stream s_*: one binary value per transfer in s_tdata[13:0].
// Master stream m_*: one transfer per shown digit, most significant first;
//   m_tlast marks the units digit, which always closes a run. Leading zeros
//   are blanked, so a value gives one to four transfers; a value above 9999
//   gives none.
// Config channel cfg_*: index 0 = hundreds dwell, 1 = dwell of the other
//   digits; other indexes are ignored. Always ready. Write only while idle.
// Path: three conversion stages, then the digit output register.
// Throughput: the conversion pipeline takes one value per cycle while
//   s_tready is high; the digit output register sends one digit per cycle
//   while m_tready is high, and takes a new value only when empty or as
//   the units digit of the last one goes; an out-of-range value is dropped
//   there unsent. Sustained rate is set by that output register.
// Reset: pipeline and output empty, dwells back to 5 ms and 2 ms.
// Stall: with m_tready low the output holds its digit, the pipeline fills
//   behind it and s_tready drops once all three stages hold a value.
module binary_to_bcd_digit_scan
	import b2bcd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// s_tdata: [13:0] value, [15:14] zero
	input  wire logic                 s_tvalid,
	output      logic                 s_tready,
	input  wire logic [15:0]          s_tdata,
	// m_tdata: [1:0] digit_position, [5:2] bcd_code, [13:6] dwell_ms,
	//          [15:14] zero
	output      logic                 m_tvalid,
	input  wire logic                 m_tready,
	output      logic [15:0]          m_tdata,
	output      logic                 m_tlast,
	input  wire logic                 cfg_valid,
	output      logic                 cfg_ready,
	input  wire logic [CfgIdxW-1:0]   cfg_index,
	input  wire logic [DwellW-1:0]    cfg_data
);

	// config registers
	logic [DwellW-1:0] dwell_hund_q;
	logic [DwellW-1:0] dwell_other_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dwell_hund_q  <= DwellHundredsRst;
			dwell_other_q <= DwellOtherRst;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				RegDwellHundreds: dwell_hund_q  <= cfg_data;
				RegDwellOther:    dwell_other_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline registers
	logic              v_s1, v_s2, v_s3;
	logic              ok_s1, ok_s2, ok_s3;   // value in range
	logic [ScrW-1:0]   scr_s1, scr_s2, scr_s3;

	// digit output register
	logic              m_valid_q;
	logic [PosW-1:0]   pos_q;
	logic [BcdW-1:0]   digits_q;

	logic en1, en2, en3;
	logic out_xfer, out_done, ser_free, load;

	assign out_xfer = m_valid_q && m_tready;
	assign out_done = out_xfer && (pos_q == PosUnits);
	assign ser_free = !m_valid_q || out_done;
	assign load     = v_s3 && ser_free;

	assign en3 = !v_s3 || ser_free;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign s_tready = en1;

	// conversion, shift-add steps spread over the three stages
	logic [ScrW-1:0] conv_in, conv_a, conv_b;

	always_comb begin
		conv_in = {BcdW'(0), s_tdata[ValueW-1:0]};
		for (int i = 0; i < StepsS1; i++) begin
			conv_in = dabble_step(conv_in);
		end
	end

	always_comb begin
		conv_a = scr_s1;
		for (int i = 0; i < StepsS2; i++) begin
			conv_a = dabble_step(conv_a);
		end
	end

	always_comb begin
		conv_b = scr_s2;
		for (int i = 0; i < StepsS3; i++) begin
			conv_b = dabble_step(conv_b);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			scr_s1 <= conv_in;
			ok_s1  <= (s_tdata[ValueW-1:0] <= MaxShown);
		end
		if (en2) begin
			scr_s2 <= conv_a;
			ok_s2  <= ok_s1;
		end
		if (en3) begin
			scr_s3 <= conv_b;
			ok_s3  <= ok_s2;
		end
	end

	// first shown digit: highest nonzero one, units at least
	logic [BcdW-1:0] bcd_s3;
	logic [PosW-1:0] start_pos;

	assign bcd_s3 = scr_s3[ScrW-1:ValueW];

	always_comb begin
		if (bcd_s3[15:12] != DigitW'(0))     start_pos = PosThousands;
		else if (bcd_s3[11:8] != DigitW'(0)) start_pos = PosHundreds;
		else if (bcd_s3[7:4] != DigitW'(0))  start_pos = PosTens;
		else                                 start_pos = PosUnits;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			pos_q     <= PosUnits;
		end else if (load) begin
			m_valid_q <= ok_s3;          // out of range: consumed, nothing sent
			pos_q     <= start_pos;
		end else if (out_done) begin
			m_valid_q <= 1'b0;
		end else if (out_xfer) begin
			pos_q <= pos_q - PosW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) digits_q <= bcd_s3;
	end

	// output fields
	logic [DigitW-1:0] cur_digit;
	logic [DwellW-1:0] cur_dwell;

	assign cur_digit = digits_q[{pos_q, 2'b00} +: DigitW];
	assign cur_dwell = (pos_q == PosHundreds) ? dwell_hund_q : dwell_other_q;

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, cur_dwell, cur_digit, pos_q};
	assign m_tlast  = (pos_q == PosUnits);

	// checks
	a_digit_dec: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (cur_digit <= DigitW'(9)))
		else $error("digit out of decimal range");

	a_next_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=>
			(m_tvalid && (pos_q == $past(pos_q) - PosW'(1))))
		else $error("digit run broken");

	a_lead_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(load && ok_s3 && (start_pos != PosUnits)) |=> (cur_digit != DigitW'(0)))
		else $error("leading zero shown");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (v_s1 && v_s2 && v_s3 && m_valid_q && !out_done))
		else $error("input stalled with room in pipeline");

endmodule

`default_nettype wire
